FILE: sv/uyvy_pkg.sv
`timescale 1ns / 1ps

package uyvy_pkg;

    localparam int SAMPLE_W  = 8;
    localparam int PIXEL_W   = 32;
    localparam int ACC_W     = 22;
    localparam int FRAC_BITS = 10;

    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic [SAMPLE_W-1:0]     t_sample;
    typedef logic [PIXEL_W-1:0]      t_pixel;

    typedef struct packed {
        t_sample chroma_blue;
        t_sample luma_first;
        t_sample chroma_red;
        t_sample luma_second;
        logic    last_in;
    } t_macropixel;

    typedef enum logic {
        ORDER_RGBA = 1'b0,
        ORDER_BGRA = 1'b1
    } t_order;

    localparam t_acc COEF_Y  = t_acc'(1192);
    localparam t_acc COEF_RV = t_acc'(1634);
    localparam t_acc COEF_GU = t_acc'(401);
    localparam t_acc COEF_GV = t_acc'(832);
    localparam t_acc COEF_BU = t_acc'(2066);
    localparam t_acc OFS_C   = t_acc'(128);
    localparam t_acc OFS_Y   = t_acc'(16);
    localparam t_acc CH_MAX  = t_acc'(255);
    localparam t_sample ALPHA = 8'hff;

    function automatic t_sample clamp_channel(t_acc acc);
        t_acc q;
        q = acc >>> FRAC_BITS;
        if (q < t_acc'(0)) begin
            return '0;
        end else if (q > CH_MAX) begin
            return '1;
        end else begin
            return q[SAMPLE_W-1:0];
        end
    endfunction

endpackage

FILE: sv/uyvy_if.sv
`timescale 1ns / 1ps

interface uyvy_in_if;
    import uyvy_pkg::*;

    logic    valid;
    logic    ready;
    t_sample chroma_blue;
    t_sample luma_first;
    t_sample chroma_red;
    t_sample luma_second;
    logic    last_in;

    modport source (
        output valid, chroma_blue, luma_first, chroma_red, luma_second, last_in,
        input  ready
    );
    modport sink (
        input  valid, chroma_blue, luma_first, chroma_red, luma_second, last_in,
        output ready
    );
endinterface

interface uyvy_out_if;
    import uyvy_pkg::*;

    logic   valid;
    logic   ready;
    t_pixel first_pixel;
    t_pixel second_pixel;
    logic   last_out;

    modport source (
        output valid, first_pixel, second_pixel, last_out,
        input  ready
    );
    modport sink (
        input  valid, first_pixel, second_pixel, last_out,
        output ready
    );
endinterface

FILE: sv/uyvy_pixel.sv
`timescale 1ns / 1ps

module uyvy_pixel (
    input  uyvy_pkg::t_sample i_luma,
    input  uyvy_pkg::t_sample i_cb,
    input  uyvy_pkg::t_sample i_cr,
    input  uyvy_pkg::t_order  i_order,
    output uyvy_pkg::t_pixel  o_pixel
);
    import uyvy_pkg::*;

    t_acc    w_y;
    t_acc    w_du;
    t_acc    w_dv;
    t_acc    w_yy;
    t_acc    w_r_acc;
    t_acc    w_g_acc;
    t_acc    w_b_acc;
    t_sample w_r;
    t_sample w_g;
    t_sample w_b;

    always_comb begin
        w_y  = t_acc'({1'b0, i_luma}) - OFS_Y;
        w_du = t_acc'({1'b0, i_cb}) - OFS_C;
        w_dv = t_acc'({1'b0, i_cr}) - OFS_C;
        w_yy = w_y * COEF_Y;

        w_r_acc = w_yy + COEF_RV * w_dv;
        w_g_acc = w_yy - COEF_GU * w_du - COEF_GV * w_dv;
        w_b_acc = w_yy + COEF_BU * w_du;

        w_r = clamp_channel(w_r_acc);
        w_g = clamp_channel(w_g_acc);
        w_b = clamp_channel(w_b_acc);
    end

    always_comb begin
        unique case (i_order)
            ORDER_BGRA: o_pixel = {ALPHA, w_r, w_g, w_b};
            default:    o_pixel = {ALPHA, w_b, w_g, w_r};
        endcase
    end

endmodule

FILE: sv/uyvy_to_rgba_converter.sv
`timescale 1ns / 1ps

// UYVY 4:2:2 to 32-bit RGBA/BGRA converter, BT.601 fixed point.
// i_in  : one macropixel per transaction (U, Y0, V, Y1 and a last flag).
// o_out : two 32-bit pixels sharing that chroma pair, plus the last flag.
// i_cfg_we/i_cfg_data write the byte order (0 = R,G,B,A from byte 0 up,
// 1 = B,G,R,A); write it only while no transaction is in flight.
// A macropixel accepted on i_in is offered on o_out from the result
// register. Throughput: one macropixel per cycle while o_out does not
// stall; the path is an input register, the per-pixel constant multiply,
// add and clamp, then a result register.
// When o_out stalls, the result register holds, the input register still
// takes one more transaction, and i_in.ready drops only once both are full.
// Reset (synchronous, active low) empties both registers and selects
// RGBA order; nothing is lost or repeated across a stall.
module uyvy_to_rgba_converter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    uyvy_in_if.sink           i_in,
    uyvy_out_if.source        o_out,
    input  logic              i_cfg_we,
    input  logic              i_cfg_data
);
    import uyvy_pkg::*;

    t_order      r_order;
    logic        r_s1_valid;
    logic        n_s1_valid;
    t_macropixel r_s1;
    logic        r_out_valid;
    logic        n_out_valid;
    t_pixel      r_out_first;
    t_pixel      r_out_second;
    logic        r_out_last;

    logic        w_out_free;
    logic        w_s1_adv;
    logic        w_in_take;
    t_pixel      w_first;
    t_pixel      w_second;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_s1_adv   = r_s1_valid && w_out_free;
    assign i_in.ready = !r_s1_valid || w_out_free;
    assign w_in_take  = i_in.valid && i_in.ready;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (w_in_take) begin
            n_s1_valid = 1'b1;
        end else if (w_s1_adv) begin
            n_s1_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (w_s1_adv) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order     <= ORDER_RGBA;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_order <= t_order'(i_cfg_data);
            end
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_s1.chroma_blue <= i_in.chroma_blue;
            r_s1.luma_first  <= i_in.luma_first;
            r_s1.chroma_red  <= i_in.chroma_red;
            r_s1.luma_second <= i_in.luma_second;
            r_s1.last_in     <= i_in.last_in;
        end
        if (w_s1_adv) begin
            r_out_first  <= w_first;
            r_out_second <= w_second;
            r_out_last   <= r_s1.last_in;
        end
    end

    uyvy_pixel u_pix_first (
        .i_luma  (r_s1.luma_first),
        .i_cb    (r_s1.chroma_blue),
        .i_cr    (r_s1.chroma_red),
        .i_order (r_order),
        .o_pixel (w_first)
    );

    uyvy_pixel u_pix_second (
        .i_luma  (r_s1.luma_second),
        .i_cb    (r_s1.chroma_blue),
        .i_cr    (r_s1.chroma_red),
        .i_order (r_order),
        .o_pixel (w_second)
    );

    assign o_out.valid        = r_out_valid;
    assign o_out.first_pixel  = r_out_first;
    assign o_out.second_pixel = r_out_second;
    assign o_out.last_out     = r_out_last;

endmodule
